// ===== src/yrc_pkg.sv =====
// Shared types, constants and pixel arithmetic for the YV12 to RGBA converter.
`default_nettype none
package yrc_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int COL_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CFG_W       = 12;
    localparam int DIM_MAX     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CMP_W       = ((CFG_W > $clog2(DIM_MAX + 1)) ?
                                  CFG_W : $clog2(DIM_MAX + 1)) + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] REG_ACTIVE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_ACTIVE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(2048);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(2048);

    // BT.601 coefficients in Q10
    localparam logic signed [12:0] COEF_Y  = 13'sd1192;
    localparam logic signed [12:0] COEF_RV = 13'sd1634;
    localparam logic signed [12:0] COEF_GV = 13'sd833;
    localparam logic signed [12:0] COEF_GU = 13'sd400;
    localparam logic signed [12:0] COEF_BU = 13'sd2066;

    localparam int SUM_W = 22;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       two;
        logic       eol;
        logic       eof;
    } yrc_item_t;

    function automatic logic [7:0] yrc_clamp(input logic signed [SUM_W-1:0] sum);
        logic [SUM_W-11:0] q;
        q = sum[SUM_W-1:10];
        if (sum < 0) begin
            return 8'd0;
        end else if (q > (SUM_W-10)'(255)) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/yv12_to_rgba_converter_unit.sv =====
// YV12 (4:2:0 planar) to RGBA converter top level.
//
// Input channel (s_*): one transaction per horizontal luma pair in raster order.
// On even rows the transaction also carries the U/V of the 2x2 group, which is
// kept in a 1024-entry chroma line store and reused on the next odd row.
// Output channel (m_*): one transaction per pixel, BT.601, R/G/B with no alpha port.
// m_end_of_line / m_end_of_frame mark row and frame ends; m_last_of_item marks
// the last pixel of each input transaction. An odd width gives one pixel at
// the row end.
// Config channel (cfg_*): index 0 = active_width, 1 = active_height; always
// ready; write only while the block is idle.
// Pixel path: input stage register, item queue, current-item register, output register.
// Throughput: one pixel per cycle while the receiver is ready, set by the output
// register; a pair gives two pixels and a single-pixel row end one; input is
// taken every cycle until the 4-entry item queue fills.
// Reset: counters return to row 0 / pair 0, sizes return to 2048x2048; the
// line store is not cleared. A stalled receiver holds the output register and
// back pressure reaches s_ready once the queue is full.
`default_nettype none
module yv12_to_rgba_converter_unit
    import yrc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_luma_first,
    input  wire logic [7:0]       s_luma_second,
    input  wire logic [7:0]       s_chroma_u,
    input  wire logic [7:0]       s_chroma_v,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_red,
    output logic [7:0]            m_green,
    output logic [7:0]            m_blue,
    output logic                  m_end_of_line,
    output logic                  m_end_of_frame,
    output logic                  m_last_of_item,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    logic      push_valid;
    logic      push_ready;
    yrc_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    yrc_item_t pop_item;

    yrc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_luma_first  (s_luma_first),
        .s_luma_second (s_luma_second),
        .s_chroma_u    (s_chroma_u),
        .s_chroma_v    (s_chroma_v),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    yrc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    yrc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_end_of_line  (m_end_of_line),
        .m_end_of_frame (m_end_of_frame),
        .m_last_of_item (m_last_of_item)
    );

endmodule
`default_nettype wire

// ===== src/yrc_front.sv =====
// Front end: input accept, size registers, position counters and chroma line store.
`default_nettype none
module yrc_front
    import yrc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_luma_first,
    input  wire logic [7:0]       s_luma_second,
    input  wire logic [7:0]       s_chroma_u,
    input  wire logic [7:0]       s_chroma_v,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output yrc_item_t             push_item
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             s1_valid_reg;
    yrc_item_t        s1_item_reg;
    logic             s1_odd_reg;
    logic [15:0]      rd_data_reg;
    logic [15:0]      store_mem [STORE_DEPTH];

    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] h_eff;
    logic [CMP_W-1:0] pairs;
    logic             two;
    logic             eol;
    logic             eof;
    logic             accept;
    logic             odd_row;

    assign cfg_ready = 1'b1;
    assign s_ready   = !s1_valid_reg || push_ready;
    assign accept    = s_valid && s_ready;
    assign odd_row   = row_reg[0];

    always_comb begin
        if (width_reg == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = CMP_W'(1);
        end else if (CMP_W'(height_reg) > CMP_W'(MAX_HEIGHT)) begin
            h_eff = CMP_W'(MAX_HEIGHT);
        end else begin
            h_eff = CMP_W'(height_reg);
        end
        pairs = (w_eff + CMP_W'(1)) >> 1;
        two   = (CMP_W'({col_reg, 1'b1}) < w_eff);
        eol   = (CMP_W'(col_reg) + CMP_W'(1)) >= pairs;
        eof   = eol && ((CMP_W'(row_reg) + CMP_W'(1)) >= h_eff);
        if (eol) begin
            col_next = '0;
            row_next = eof ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_ACTIVE_WIDTH:  width_reg  <= cfg_data;
                    REG_ACTIVE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg.luma_first  <= s_luma_first;
            s1_item_reg.luma_second <= s_luma_second;
            s1_item_reg.chroma_u    <= s_chroma_u;
            s1_item_reg.chroma_v    <= s_chroma_v;
            s1_item_reg.two         <= two;
            s1_item_reg.eol         <= eol;
            s1_item_reg.eof         <= eof;
            s1_odd_reg              <= odd_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !odd_row) begin
            store_mem[col_reg] <= {s_chroma_u, s_chroma_v};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= store_mem[col_reg];
        end
    end

    always_comb begin
        push_valid = s1_valid_reg;
        push_item  = s1_item_reg;
        if (s1_odd_reg) begin
            push_item.chroma_u = rd_data_reg[15:8];
            push_item.chroma_v = rd_data_reg[7:0];
        end
    end

endmodule
`default_nettype wire

// ===== src/yrc_queue.sv =====
// Short item queue between the front end and the pixel back end.
`default_nettype none
module yrc_queue
    import yrc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire yrc_item_t push_item,
    output logic           pop_valid,
    input  wire logic      pop_ready,
    output yrc_item_t      pop_item
);

    yrc_item_t         q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = q_mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== src/yrc_back.sv =====
// Back end: splits an item into pixels, BT.601 conversion and output register.
`default_nettype none
module yrc_back
    import yrc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      pop_valid,
    output logic           pop_ready,
    input  wire yrc_item_t pop_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output logic [7:0]     m_red,
    output logic [7:0]     m_green,
    output logic [7:0]     m_blue,
    output logic           m_end_of_line,
    output logic           m_end_of_frame,
    output logic           m_last_of_item
);

    logic                   cur_valid_reg;
    yrc_item_t              cur_reg;
    logic                   phase_reg;
    logic                   m_valid_reg;
    logic [7:0]             red_reg;
    logic [7:0]             green_reg;
    logic [7:0]             blue_reg;
    logic                   eol_reg;
    logic                   eof_reg;
    logic                   last_reg;

    logic                   out_free;
    logic                   adv;
    logic                   done;
    logic [7:0]             luma;
    logic signed [9:0]      yd;
    logic signed [9:0]      ud;
    logic signed [9:0]      vd;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] g_sum;
    logic signed [SUM_W-1:0] b_sum;

    assign out_free  = !m_valid_reg || m_ready;
    assign adv       = cur_valid_reg && out_free;
    assign done      = !cur_reg.two || phase_reg;
    assign pop_ready = !cur_valid_reg || (adv && done);

    always_comb begin
        luma  = phase_reg ? cur_reg.luma_second : cur_reg.luma_first;
        yd    = $signed({2'b00, luma}) - 10'sd16;
        ud    = $signed({2'b00, cur_reg.chroma_u}) - 10'sd128;
        vd    = $signed({2'b00, cur_reg.chroma_v}) - 10'sd128;
        r_sum = COEF_Y * yd + COEF_RV * vd;
        g_sum = COEF_Y * yd - COEF_GV * vd - COEF_GU * ud;
        b_sum = COEF_Y * yd + COEF_BU * ud;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop_ready) begin
                cur_valid_reg <= pop_valid;
                phase_reg     <= 1'b0;
            end else if (adv) begin
                phase_reg <= 1'b1;
            end
            if (out_free) begin
                m_valid_reg <= cur_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            cur_reg <= pop_item;
        end
        if (adv) begin
            red_reg   <= yrc_clamp(r_sum);
            green_reg <= yrc_clamp(g_sum);
            blue_reg  <= yrc_clamp(b_sum);
            last_reg  <= done;
            eol_reg   <= done && cur_reg.eol;
            eof_reg   <= done && cur_reg.eof;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_end_of_line  = eol_reg;
    assign m_end_of_frame = eof_reg;
    assign m_last_of_item = last_reg;

endmodule
`default_nettype wire
